[hw/rtl/mbrtu_pkg.sv]
package mbrtu_pkg;

    // input action codes (slave tuser)
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // frame status codes (master tuser)
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_CRC    = 2'd2;
    localparam logic [1:0] ST_HEADER = 2'd3;

    // configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_FRAME_KIND     = 1'b1;

    localparam logic [7:0] ADDR_RESET      = 8'd248;
    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0] FUNC_RESET_ECHO = 8'h42;
    localparam logic [7:0] READ_BYTE_COUNT = 8'd20;
    localparam logic [4:0] READ_FRAME_LEN  = 5'd25;
    localparam logic [4:0] ECHO_FRAME_LEN  = 5'd4;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int OUT_DATA_W = 192;

    // one byte of the reflected modbus crc-16
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/modbus_rtu_meter_response_parser.sv]
// modbus rtu reply parser for a power meter
//
// slave stream: one word per received uart byte, tuser carries the action
// (received byte, start of frame, response timeout), tdata the byte itself.
// a start word clears the frame state; bytes are then checked and captured,
// and the last byte of the expected frame (25 for a measurement read reply,
// 4 for an energy reset echo) or a timeout yields exactly one result word.
// master stream: tuser is the frame status, tdata the readings and the
// voltage times current product; readings are zero unless the status is ok
// on a measurement reply. bytes after a result are dropped until the next start.
// config port: write enable, register index, 8 bit data; the user must keep it
// written only while idle, since the block itself does not enforce this.
// throughput: one word per cycle while the result register is free or draining,
// set by the crc byte update and field capture between the input register and
// the result register; a word passes both in turn before its result is valid.
// reset (synchronous, active low) empties both registers, clears the frame
// state and loads the default address 248 and the measurement frame kind.
// when the receiver stalls, the result stays put and one more input word is
// held in the input register; after that tready drops until the result leaves.
module modbus_rtu_meter_response_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config port
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // rx_byte
    input  logic [1:0]                        s_axis_tuser,  // action
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // voltage_tenths, current_milliamps, power_tenths_watt, energy_watt_hours,
    // frequency_tenths, power_factor_hundredths, apparent_power
    output logic [mbrtu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                        m_axis_tuser   // frame_status
);

    // configuration
    logic [7:0]  r_dev_addr;
    logic        r_frame_kind;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_action;
    logic [7:0]  r_byte;

    // frame state
    logic [4:0]  r_byte_count, n_byte_count;
    logic [15:0] r_crc, n_crc;
    logic        r_header_good, n_header_good;
    logic [7:0]  r_crc_low, n_crc_low;
    logic [15:0] r_voltage, n_voltage;
    logic [31:0] r_current, n_current;
    logic [31:0] r_power, n_power;
    logic [31:0] r_energy, n_energy;
    logic [15:0] r_frequency, n_frequency;
    logic [15:0] r_factor, n_factor;
    logic        r_frame_done, n_frame_done;

    // result register
    logic                             r_out_valid;
    logic [1:0]                       r_out_status;
    logic [mbrtu_pkg::OUT_DATA_W-1:0] r_out_data;

    logic        w_advance;
    logic        w_emit;
    logic [1:0]  w_status;
    logic        w_show;
    logic [4:0]  w_len;
    logic [47:0] w_product;

    // input register moves on when the result slot is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= mbrtu_pkg::ADDR_RESET;
            r_frame_kind <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbrtu_pkg::CFG_DEVICE_ADDRESS: r_dev_addr   <= i_cfg_data;
                mbrtu_pkg::CFG_FRAME_KIND:     r_frame_kind <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_action <= s_axis_tuser;
            r_byte   <= s_axis_tdata;
        end
    end

    // frame length of the selected kind
    assign w_len = r_frame_kind ? mbrtu_pkg::ECHO_FRAME_LEN : mbrtu_pkg::READ_FRAME_LEN;

    always_comb begin
        n_byte_count  = r_byte_count;
        n_crc         = r_crc;
        n_header_good = r_header_good;
        n_crc_low     = r_crc_low;
        n_voltage     = r_voltage;
        n_current     = r_current;
        n_power       = r_power;
        n_energy      = r_energy;
        n_frequency   = r_frequency;
        n_factor      = r_factor;
        n_frame_done  = r_frame_done;
        w_emit        = 1'b0;
        w_status      = mbrtu_pkg::ST_OK;

        if (w_advance) begin
            case (r_action)
                mbrtu_pkg::ACT_START: begin
                    n_byte_count  = 5'd0;
                    n_crc         = mbrtu_pkg::CRC_INIT;
                    n_header_good = 1'b1;
                    n_crc_low     = 8'd0;
                    n_voltage     = 16'd0;
                    n_current     = 32'd0;
                    n_power       = 32'd0;
                    n_energy      = 32'd0;
                    n_frequency   = 16'd0;
                    n_factor      = 16'd0;
                    n_frame_done  = 1'b0;
                end
                mbrtu_pkg::ACT_TIMEOUT: begin
                    if (!r_frame_done) begin
                        w_emit       = 1'b1;
                        w_status     = mbrtu_pkg::ST_SHORT;
                        n_frame_done = 1'b1;
                    end
                end
                mbrtu_pkg::ACT_BYTE: begin
                    // bytes past the end of the current kind are dropped
                    if (!r_frame_done && (r_byte_count < w_len)) begin
                        n_byte_count = r_byte_count + 5'd1;
                        if (r_byte_count < (w_len - 5'd2)) begin
                            n_crc = mbrtu_pkg::crc16_byte(r_crc, r_byte);
                            if (r_byte_count == 5'd0 && r_byte != r_dev_addr) begin
                                n_header_good = 1'b0;
                            end
                            if (r_byte_count == 5'd1 && r_byte != (r_frame_kind ?
                                    mbrtu_pkg::FUNC_RESET_ECHO :
                                    mbrtu_pkg::FUNC_READ_INPUT)) begin
                                n_header_good = 1'b0;
                            end
                            if (!r_frame_kind) begin
                                if (r_byte_count == 5'd2 &&
                                        r_byte != mbrtu_pkg::READ_BYTE_COUNT) begin
                                    n_header_good = 1'b0;
                                end
                                // big-endian words, 32 bit values low word first
                                case (r_byte_count)
                                    5'd3:  n_voltage[15:8]    = r_byte;
                                    5'd4:  n_voltage[7:0]     = r_byte;
                                    5'd5:  n_current[15:8]    = r_byte;
                                    5'd6:  n_current[7:0]     = r_byte;
                                    5'd7:  n_current[31:24]   = r_byte;
                                    5'd8:  n_current[23:16]   = r_byte;
                                    5'd9:  n_power[15:8]      = r_byte;
                                    5'd10: n_power[7:0]       = r_byte;
                                    5'd11: n_power[31:24]     = r_byte;
                                    5'd12: n_power[23:16]     = r_byte;
                                    5'd13: n_energy[15:8]     = r_byte;
                                    5'd14: n_energy[7:0]      = r_byte;
                                    5'd15: n_energy[31:24]    = r_byte;
                                    5'd16: n_energy[23:16]    = r_byte;
                                    5'd17: n_frequency[15:8]  = r_byte;
                                    5'd18: n_frequency[7:0]   = r_byte;
                                    5'd19: n_factor[15:8]     = r_byte;
                                    5'd20: n_factor[7:0]      = r_byte;
                                    default: ;
                                endcase
                            end
                        end else if (r_byte_count == (w_len - 5'd2)) begin
                            n_crc_low = r_byte;
                        end else begin
                            // crc mismatch wins over a bad header
                            w_emit       = 1'b1;
                            n_frame_done = 1'b1;
                            if ({r_byte, r_crc_low} != r_crc) begin
                                w_status = mbrtu_pkg::ST_CRC;
                            end else if (!r_header_good) begin
                                w_status = mbrtu_pkg::ST_HEADER;
                            end else begin
                                w_status = mbrtu_pkg::ST_OK;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= 5'd0;
            r_crc         <= mbrtu_pkg::CRC_INIT;
            r_header_good <= 1'b1;
            r_crc_low     <= 8'd0;
            r_voltage     <= 16'd0;
            r_current     <= 32'd0;
            r_power       <= 32'd0;
            r_energy      <= 32'd0;
            r_frequency   <= 16'd0;
            r_factor      <= 16'd0;
            r_frame_done  <= 1'b0;
        end else begin
            r_byte_count  <= n_byte_count;
            r_crc         <= n_crc;
            r_header_good <= n_header_good;
            r_crc_low     <= n_crc_low;
            r_voltage     <= n_voltage;
            r_current     <= n_current;
            r_power       <= n_power;
            r_energy      <= n_energy;
            r_frequency   <= n_frequency;
            r_factor      <= n_factor;
            r_frame_done  <= n_frame_done;
        end
    end

    // readings only go out on a good measurement reply
    assign w_show    = (w_status == mbrtu_pkg::ST_OK) && !r_frame_kind;
    assign w_product = {32'd0, r_voltage} * {16'd0, r_current};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_status <= w_status;
            if (w_show) begin
                r_out_data <= {w_product, r_factor, r_frequency, r_energy,
                               r_power, r_current, r_voltage};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = r_out_data;

endmodule

[hw/rtl/mbrtu_checker.sv]
module mbrtu_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mbrtu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                        m_axis_tuser
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // failed frames carry no readings
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != mbrtu_pkg::ST_OK) |-> m_axis_tdata == '0)
        else $error("readings not cleared on failed frame");

    // product field matches the voltage and current fields
    a_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[191:144] ==
                ({32'd0, m_axis_tdata[15:0]} * {16'd0, m_axis_tdata[47:16]}))
        else $error("apparent power mismatch");

    // input only backs up behind a waiting result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind modbus_rtu_meter_response_parser mbrtu_checker u_mbrtu_checker (.*);
